// ===== sv/pbd_pkg.sv =====
// Shared widths, constants and pipeline payload types for the distance constraint block.
// No dependencies; the top level and the checker refer to it by scoped names.
package pbd_pkg;

    localparam int POS_W       = 32;
    localparam int DIFF_W      = 33;
    localparam int WGT_W       = 24;
    localparam int WSUM_W      = 25;
    localparam int LEN_W       = 31;
    localparam int STIFF_W     = 17;
    localparam int WF          = 16;
    localparam int FRAC_BITS_D = 16;
    localparam int SQ_W        = 66;
    localparam int ROOT_W      = 35;
    localparam int SHARE_W     = 17;
    localparam int EMAG_W      = 35;
    localparam int Q_W         = 48;
    localparam int G_W         = 49;
    localparam int CORR_W      = 41;

    localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
    localparam logic [CORR_W-1:0]  CORR_CAP    = 41'h100_0000_0000;

    typedef logic [2:0][POS_W-1:0]  pos3_t;
    typedef logic [2:0][DIFF_W-1:0] mag3_t;

    typedef struct packed {
        pos3_t              pa;
        pos3_t              pb;
        mag3_t              dm;
        logic [2:0]         dneg;
        logic [WGT_W-1:0]   wa;
        logic [WGT_W-1:0]   wb;
        logic [WSUM_W-1:0]  wsum;
        logic [LEN_W-1:0]   len;
    } front_t;

    typedef struct packed {
        pos3_t              pa;
        pos3_t              pb;
        mag3_t              dm;
        logic [2:0]         dneg;
        logic [SHARE_W-1:0] ka;
        logic [SHARE_W-1:0] kb;
        logic               eneg;
        logic               degen;
    } tail_t;

endpackage

// ===== sv/pbd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the caller keeps the dividend below den * 2^QW.
module pbd_div #(
    parameter int NW = 40,
    parameter int DW = 25,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int W = (NW > DW) ? NW : DW;

    logic [NW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [W-1:0]  remx;
        logic [W-1:0]  denx;
        logic          fit;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign remx = W'(rem_in);
        assign denx = W'(den_in);
        assign fit  = (remx >> (QW-1-k)) >= denx;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_in | (fit ? (QW'(1) << (QW-1-k)) : QW'(0));
            end
        end

        if (k < QW-1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fit ? NW'(remx - (denx << (QW-1-k))) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== sv/pbd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on nothing; the root of the SW-bit operand must fit in RW bits.
module pbd_isqrt #(
    parameter int SW = 66,
    parameter int RW = 35
) (
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] sq,
    output logic [RW-1:0] root
);

    localparam int TW = (2*RW+1 > SW) ? 2*RW+1 : SW;

    logic [SW-1:0] rem_reg  [RW-1];
    logic [RW-1:0] root_reg [RW];

    genvar k;
    for (k = 0; k < RW; k++) begin : g_stage
        logic [SW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [TW-1:0] remx;
        logic [TW-1:0] trial;
        logic          fit;

        if (k == 0) begin : g_first
            assign rem_in  = sq;
            assign root_in = '0;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign remx  = TW'(rem_in);
        assign trial = (TW'(root_in) << (RW-k)) | (TW'(1) << (2*(RW-1-k)));
        assign fit   = remx >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_in | (fit ? (RW'(1) << (RW-1-k)) : RW'(0));
            end
        end

        if (k < RW-1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fit ? SW'(remx - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ===== sv/pbd_distance_constraint.sv =====
// Distance constraint projector: top level with the full item pipeline.
// Depends on pbd_pkg, pbd_isqrt and pbd_div.
//
// One item enters per cycle while in_stall is low, and its result passes through the
// 35-stage square root and the 48-stage divider for (d - L) / d, each retiring
// one bit per stage. The pipeline moves as one: when the output holds an item
// that is stalled, every stage holds and in_stall rises in the same cycle.
// Stiffness is read live, so write it only while no item is in flight.
module pbd_distance_constraint #(
    parameter int FRAC_BITS = pbd_pkg::FRAC_BITS_D
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 stiffness_we,
    input  logic [pbd_pkg::STIFF_W-1:0]          stiffness_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_a_x,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_a_y,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_a_z,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_b_x,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_b_y,
    input  logic signed [pbd_pkg::POS_W-1:0]     pos_b_z,
    input  logic [pbd_pkg::WGT_W-1:0]            weight_a,
    input  logic [pbd_pkg::WGT_W-1:0]            weight_b,
    input  logic [pbd_pkg::LEN_W-1:0]            rest_length,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pbd_pkg::POS_W-1:0]     new_a_x,
    output logic signed [pbd_pkg::POS_W-1:0]     new_a_y,
    output logic signed [pbd_pkg::POS_W-1:0]     new_a_z,
    output logic signed [pbd_pkg::POS_W-1:0]     new_b_x,
    output logic signed [pbd_pkg::POS_W-1:0]     new_b_y,
    output logic signed [pbd_pkg::POS_W-1:0]     new_b_z,
    output logic                                 applied
);

    localparam int ROOT_W  = pbd_pkg::ROOT_W;
    localparam int SHARE_W = pbd_pkg::SHARE_W;
    localparam int Q_W     = pbd_pkg::Q_W;
    localparam int WF      = pbd_pkg::WF;
    localparam int SH_TAP  = ROOT_W - 1 - SHARE_W;
    localparam int NV      = 4 + ROOT_W + 1 + Q_W + 4;
    localparam logic [ROOT_W-1:0] EPS_D =
        ROOT_W'((64'd1 << FRAC_BITS) / 64'd10000000);

    function automatic logic [pbd_pkg::POS_W-1:0] sat_pos(input logic [42:0] v);
        logic [pbd_pkg::POS_W-1:0] r;
        if (!v[42] && (v[41:31] != 11'h000))
            r = 32'h7fff_ffff;
        else if (v[42] && (v[41:31] != 11'h7ff))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic                          en;
    logic [NV-1:0]                 v_reg;
    logic [pbd_pkg::STIFF_W-1:0]   stiff_reg;

    pbd_pkg::front_t               f0_reg, f1_reg, f2_reg, f3_reg;
    pbd_pkg::front_t               f1_next;
    logic [2:0][64:0]              sq_reg;
    logic [pbd_pkg::SQ_W-1:0]      s_reg;
    pbd_pkg::front_t               sd_reg [ROOT_W];
    logic [ROOT_W-1:0]             root;
    logic [SHARE_W-1:0]            sha, shb;

    pbd_pkg::tail_t                t4_reg, t4_next;
    logic [ROOT_W-1:0]             d4_reg;
    logic [pbd_pkg::EMAG_W-1:0]    emag4_reg, emag4_next;
    pbd_pkg::tail_t                qd_reg [Q_W];
    logic [Q_W-1:0]                qm;

    pbd_pkg::tail_t                t5_reg, t6_reg, t7_reg;
    logic [pbd_pkg::G_W-1:0]       ga5_reg, gb5_reg, ga5_next, gb5_next;
    logic [2:0][57:0]              pla6_reg, plb6_reg;
    logic [2:0][56:0]              pha6_reg, phb6_reg;
    logic [2:0][pbd_pkg::CORR_W-1:0] ca7_reg, cb7_reg, ca7_next, cb7_next;
    pbd_pkg::pos3_t                na_reg, nb_reg, na_next, nb_next;
    logic                          app_reg;

    assign en       = !v_reg[NV-1] || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            stiff_reg <= pbd_pkg::STIFF_RESET;
        end
        else
        begin
            if (en)
                v_reg <= {v_reg[NV-2:0], in_valid};
            if (stiffness_we)
                stiff_reg <= stiffness_wdata;
        end
    end

    // front: capture, difference, squares, sum
    always_comb
    begin
        logic [pbd_pkg::DIFF_W-1:0] df;
        f1_next = f0_reg;
        for (int i = 0; i < 3; i++)
        begin
            df = {f0_reg.pa[i][31], f0_reg.pa[i]} - {f0_reg.pb[i][31], f0_reg.pb[i]};
            f1_next.dneg[i] = df[32];
            f1_next.dm[i]   = df[32] ? (33'd0 - df) : df;
        end
        f1_next.wsum = {1'b0, f0_reg.wa} + {1'b0, f0_reg.wb};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg.pa   <= {pos_a_z, pos_a_y, pos_a_x};
            f0_reg.pb   <= {pos_b_z, pos_b_y, pos_b_x};
            f0_reg.dm   <= '0;
            f0_reg.dneg <= '0;
            f0_reg.wa   <= weight_a;
            f0_reg.wb   <= weight_b;
            f0_reg.wsum <= '0;
            f0_reg.len  <= rest_length;
            f1_reg      <= f1_next;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 65'(66'(f1_reg.dm[i]) * 66'(f1_reg.dm[i]));
            f2_reg      <= f1_reg;
            s_reg       <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
            f3_reg      <= f2_reg;
            sd_reg[0]   <= f3_reg;
            for (int k = 1; k < ROOT_W; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    pbd_isqrt #(
        .SW (pbd_pkg::SQ_W),
        .RW (ROOT_W)
    ) u_isqrt (
        .clk  (clk),
        .en   (en),
        .sq   (s_reg),
        .root (root)
    );

    pbd_div #(
        .NW (pbd_pkg::WGT_W + WF),
        .DW (pbd_pkg::WSUM_W),
        .QW (SHARE_W)
    ) u_share_a (
        .clk (clk),
        .en  (en),
        .num ({sd_reg[SH_TAP].wa, WF'(0)}),
        .den (sd_reg[SH_TAP].wsum),
        .quo (sha)
    );

    pbd_div #(
        .NW (pbd_pkg::WGT_W + WF),
        .DW (pbd_pkg::WSUM_W),
        .QW (SHARE_W)
    ) u_share_b (
        .clk (clk),
        .en  (en),
        .num ({sd_reg[SH_TAP].wb, WF'(0)}),
        .den (sd_reg[SH_TAP].wsum),
        .quo (shb)
    );

    // weight shares times stiffness, signed length error, degenerate check
    always_comb
    begin
        logic [33:0]     kpa, kpb;
        logic [ROOT_W:0] e;
        kpa = 34'(sha) * 34'(stiff_reg);
        kpb = 34'(shb) * 34'(stiff_reg);
        e   = {1'b0, root} - (ROOT_W+1)'(sd_reg[ROOT_W-1].len);
        t4_next.pa    = sd_reg[ROOT_W-1].pa;
        t4_next.pb    = sd_reg[ROOT_W-1].pb;
        t4_next.dm    = sd_reg[ROOT_W-1].dm;
        t4_next.dneg  = sd_reg[ROOT_W-1].dneg;
        t4_next.ka    = kpa[32:16];
        t4_next.kb    = kpb[32:16];
        t4_next.eneg  = e[ROOT_W];
        t4_next.degen = (sd_reg[ROOT_W-1].wsum == '0) || (root <= EPS_D);
        emag4_next    = e[ROOT_W] ? pbd_pkg::EMAG_W'(-e) : pbd_pkg::EMAG_W'(e);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_reg    <= t4_next;
            d4_reg    <= root;
            emag4_reg <= emag4_next;
            qd_reg[0] <= t4_reg;
            for (int k = 1; k < Q_W; k++)
                qd_reg[k] <= qd_reg[k-1];
        end
    end

    pbd_div #(
        .NW (pbd_pkg::EMAG_W + WF),
        .DW (ROOT_W),
        .QW (Q_W)
    ) u_ratio (
        .clk (clk),
        .en  (en),
        .num ({emag4_reg, WF'(0)}),
        .den (d4_reg),
        .quo (qm)
    );

    // gains, split products, capped corrections, saturated sums
    always_comb
    begin
        logic [64:0] gpa, gpb;
        logic [82:0] fa, fb;
        logic [42:0] pax, pbx, cax, cbx;
        logic        neg;
        gpa = 65'(qd_reg[Q_W-1].ka) * 65'(qm);
        gpb = 65'(qd_reg[Q_W-1].kb) * 65'(qm);
        ga5_next = gpa[64:16];
        gb5_next = gpb[64:16];
        for (int i = 0; i < 3; i++)
        begin
            fa = 83'(pla6_reg[i]) + (83'(pha6_reg[i]) << 25);
            fb = 83'(plb6_reg[i]) + (83'(phb6_reg[i]) << 25);
            ca7_next[i] = (fa[82:16] > 67'(pbd_pkg::CORR_CAP)) ? pbd_pkg::CORR_CAP : fa[56:16];
            cb7_next[i] = (fb[82:16] > 67'(pbd_pkg::CORR_CAP)) ? pbd_pkg::CORR_CAP : fb[56:16];
            pax = {{11{t7_reg.pa[i][31]}}, t7_reg.pa[i]};
            pbx = {{11{t7_reg.pb[i][31]}}, t7_reg.pb[i]};
            cax = {2'b00, ca7_reg[i]};
            cbx = {2'b00, cb7_reg[i]};
            neg = t7_reg.eneg != t7_reg.dneg[i];
            na_next[i] = t7_reg.degen ? t7_reg.pa[i] : sat_pos(neg ? pax + cax : pax - cax);
            nb_next[i] = t7_reg.degen ? t7_reg.pb[i] : sat_pos(neg ? pbx - cbx : pbx + cbx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_reg  <= qd_reg[Q_W-1];
            ga5_reg <= ga5_next;
            gb5_reg <= gb5_next;
            t6_reg  <= t5_reg;
            for (int i = 0; i < 3; i++)
            begin
                pla6_reg[i] <= 58'(ga5_reg[24:0]) * 58'(t5_reg.dm[i]);
                pha6_reg[i] <= 57'(ga5_reg[48:25]) * 57'(t5_reg.dm[i]);
                plb6_reg[i] <= 58'(gb5_reg[24:0]) * 58'(t5_reg.dm[i]);
                phb6_reg[i] <= 57'(gb5_reg[48:25]) * 57'(t5_reg.dm[i]);
            end
            t7_reg  <= t6_reg;
            ca7_reg <= ca7_next;
            cb7_reg <= cb7_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            app_reg <= !t7_reg.degen;
        end
    end

    assign out_valid = v_reg[NV-1];
    assign new_a_x   = na_reg[0];
    assign new_a_y   = na_reg[1];
    assign new_a_z   = na_reg[2];
    assign new_b_x   = nb_reg[0];
    assign new_b_y   = nb_reg[1];
    assign new_b_z   = nb_reg[2];
    assign applied   = app_reg;

endmodule

// ===== sv/pbd_checker.sv =====
// Port-level checker for the distance constraint block, bound to the top level.
// Depends on pbd_pkg and pbd_distance_constraint.
module pbd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [pbd_pkg::POS_W-1:0]     new_a_x,
    input logic                          applied
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_a_x) && $stable(applied))
        else $error("output item changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without a stalled output item");

    a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !in_stall || out_valid)
        else $error("input stalled after output drained");

    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind pbd_distance_constraint pbd_checker u_pbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_a_x   (new_a_x),
    .applied   (applied)
);
